// ===== rtl/stg_pkg.sv =====
// Shared constants, types and the note period lookup for the stepper tone generator.
package stg_pkg;

    localparam int SWEEP_STEPS = 314;
    localparam int TIME_WIDTH  = 32;
    localparam int SWEEP_W     = $clog2(SWEEP_STEPS);
    localparam int PERIOD_W    = 17;
    localparam int HALF_W      = 16;
    localparam int CNT_W       = $clog2(TIME_WIDTH + 1);

    typedef enum logic [1:0] {
        FUNC_TICK     = 2'd0,
        FUNC_NOTE_ON  = 2'd1,
        FUNC_NOTE_OFF = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } state_t;

    // integer part of 800000*2^(k/12)/11
    localparam logic [17:0] SEMITONE_BASE [12] = '{
        18'd72727,  18'd77051,  18'd81633,  18'd86487,
        18'd91630,  18'd97079,  18'd102851, 18'd108967,
        18'd115447, 18'd122312, 18'd129585, 18'd137290
    };

    function automatic logic [PERIOD_W-1:0] note_period(input logic [6:0] note);
        logic [7:0]  t;
        logic [3:0]  oct;
        logic [7:0]  oct_x12;
        logic [3:0]  semi;
        logic [3:0]  shamt;
        logic [17:0] base;
        t   = 8'd129 - {1'b0, note};
        oct = 4'd0;
        // octave = t / 12 by compare against each multiple
        for (int k = 1; k <= 10; k++) begin
            if (t >= 8'(12 * k)) begin
                oct = 4'(k);
            end
        end
        oct_x12 = ({4'd0, oct} << 3) + ({4'd0, oct} << 2);
        semi    = 4'(t - oct_x12);
        shamt   = 4'd10 - oct;
        base    = SEMITONE_BASE[semi];
        return PERIOD_W'(base >> shamt);
    endfunction

endpackage

// ===== rtl/stg_mod_unit.sv =====
// Iterative restoring remainder unit: one dividend bit per cycle.
module stg_mod_unit
    import stg_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [TIME_WIDTH-1:0] dividend,
    input  logic [PERIOD_W-1:0]   divisor,
    output logic                  done,
    output logic [PERIOD_W-1:0]   remainder
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [TIME_WIDTH-1:0] dvd_reg, dvd_next;
    logic [PERIOD_W-1:0]   div_reg, div_next;
    logic [PERIOD_W-1:0]   rem_reg, rem_next;
    logic [PERIOD_W:0]     trial;

    assign trial = {rem_reg, dvd_reg[TIME_WIDTH-1]};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(TIME_WIDTH);
            dvd_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            // remainder stays below divisor, so the difference fits PERIOD_W bits
            if (trial >= {1'b0, div_reg}) begin
                rem_next = PERIOD_W'(trial - {1'b0, div_reg});
            end else begin
                rem_next = trial[PERIOD_W-1:0];
            end
            dvd_next = dvd_reg << 1;
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/stepper_tone_step_dir_generator.sv =====
// Top level: note/tick sequencer, tone state and result register.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | s_func, s_note, s_now_us
//  m_      | out       | m_valid / m_ready  | m_step_level, m_dir_level,
//          |           |                    | m_step_changed, m_dir_changed
//
// A sounding tick waits in ST_DIV for the bit-per-cycle remainder unit;
// note-on, note-off and silent ticks go from ST_IDLE straight to ST_DONE.
// One transaction is in work at a time; the result register lets the next
// transaction be accepted while the last result waits for m_ready.
// aresetn is synchronous, active low, and silences the generator.
module stepper_tone_step_dir_generator
    import stg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [6:0]  s_note,
    input  logic [31:0] s_now_us,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_step_level,
    output logic        m_dir_level,
    output logic        m_step_changed,
    output logic        m_dir_changed
);

    state_t                state_reg, state_next;
    logic [1:0]            func_reg;
    logic [6:0]            note_reg;
    logic [PERIOD_W-1:0]   period_reg, period_next;
    logic [HALF_W-1:0]     half_reg, half_next;
    logic                  phase_reg, phase_next;
    logic                  pin_reg, pin_next;
    logic [SWEEP_W-1:0]    sweep_reg, sweep_next;
    logic                  dir_reg, dir_next;
    logic                  m_valid_reg, m_valid_next;
    logic                  step_chg_reg, step_chg_next;
    logic                  dir_chg_reg, dir_chg_next;
    logic                  out_step_reg, out_dir_reg;

    logic                  accept;
    logic                  mod_start;
    logic                  mod_done;
    logic [PERIOD_W-1:0]   mod_rem;
    logic                  commit;
    logic                  want;
    logic [PERIOD_W-1:0]   rom_period;
    logic [SWEEP_W:0]      sweep_inc;

    assign accept = s_valid && s_ready;

    stg_mod_unit u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (mod_start),
        .dividend  (TIME_WIDTH'(s_now_us)),
        .divisor   (period_reg),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    // sequencer
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        mod_start  = 1'b0;
        commit     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_func == FUNC_TICK && period_reg != '0) begin
                        mod_start  = 1'b1;
                        state_next = ST_DIV;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DIV: begin
                if (mod_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign rom_period = note_period(note_reg);
    assign want       = ({1'b0, half_reg} >= mod_rem);
    assign sweep_inc  = {1'b0, sweep_reg} + (SWEEP_W+1)'(1);

    // state update at commit
    always_comb begin
        period_next   = period_reg;
        half_next     = half_reg;
        phase_next    = phase_reg;
        pin_next      = pin_reg;
        sweep_next    = sweep_reg;
        dir_next      = dir_reg;
        step_chg_next = 1'b0;
        dir_chg_next  = 1'b0;
        if (commit) begin
            if (func_reg == FUNC_NOTE_ON) begin
                period_next = rom_period;
                half_next   = HALF_W'(rom_period >> 1);
            end else if (func_reg == FUNC_NOTE_OFF) begin
                period_next = '0;
                half_next   = '0;
                phase_next  = 1'b0;
            end else if (func_reg == FUNC_TICK && period_reg != '0 && want != phase_reg) begin
                phase_next    = !phase_reg;
                pin_next      = !phase_reg;
                step_chg_next = 1'b1;
                if (sweep_inc >= (SWEEP_W+1)'(SWEEP_STEPS)) begin
                    sweep_next = '0;
                end else begin
                    sweep_next = sweep_inc[SWEEP_W-1:0];
                end
                dir_next     = (sweep_next > SWEEP_W'(SWEEP_STEPS / 2));
                dir_chg_next = (dir_next != dir_reg);
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            period_reg  <= '0;
            half_reg    <= '0;
            phase_reg   <= 1'b0;
            pin_reg     <= 1'b0;
            sweep_reg   <= '0;
            dir_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            period_reg  <= period_next;
            half_reg    <= half_next;
            phase_reg   <= phase_next;
            pin_reg     <= pin_next;
            sweep_reg   <= sweep_next;
            dir_reg     <= dir_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg <= s_func;
            note_reg <= s_note;
        end
        if (commit) begin
            out_step_reg <= pin_next;
            out_dir_reg  <= dir_next;
            step_chg_reg <= step_chg_next;
            dir_chg_reg  <= dir_chg_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_step_level   = out_step_reg;
    assign m_dir_level    = out_dir_reg;
    assign m_step_changed = step_chg_reg;
    assign m_dir_changed  = dir_chg_reg;

    // a direction change only comes with a step toggle
    a_dir_needs_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_dir_changed |-> m_step_changed)
        else $error("direction changed without a step toggle");

    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        mod_done |-> state_reg == ST_DIV)
        else $error("remainder finished outside the divide state");

    a_sweep_range: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, sweep_reg} < (SWEEP_W+1)'(SWEEP_STEPS))
        else $error("sweep count out of range");

    a_silent_half: assert property (@(posedge aclk) disable iff (!aresetn)
        period_reg == '0 |-> half_reg == '0)
        else $error("half period set while silent");

endmodule
